>>> sv/ewhe_pkg.sv
// Shared types and constants for the windowed header byte entropy core.
package ewhe_pkg;

  // Default sizes for the top-level parameters
  localparam int unsigned SLOTS_DEF       = 64;
  localparam int unsigned COUNT_WIDTH_DEF = 24;
  localparam int unsigned FRAC_BITS_DEF   = 12;

  // Depth of the queue between the parser and the back end
  localparam int unsigned QUEUE_DEPTH = 4;

  // Frame parsing constants
  localparam logic [3:0] ETH_REST     = 4'd13;
  localparam logic [7:0] IHL_MASK     = 8'h0f;
  localparam logic [6:0] WINDOW_RESET = 7'd3;
  localparam logic [15:0] INTERVAL_MAX = 16'hFFFF;
  localparam logic [15:0] ENTROPY_MAX  = 16'hFFFF;

  // Input command codes
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef enum logic {
    ITEM_COUNT = 1'b0,
    ITEM_TICK  = 1'b1
  } item_kind_e;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
    logic       packet_start;
  } in_item_t;

  typedef struct packed {
    logic [15:0] entropy_bits;
    logic [15:0] closed_interval;
    logic [31:0] packets_seen;
  } out_item_t;

  typedef struct packed {
    item_kind_e  kind;
    logic [7:0]  sym;
    logic [31:0] pkts;
  } q_item_t;

endpackage

>>> sv/windowed_header_byte_entropy_core.sv
// Top level of the windowed header byte entropy core.
//
//  channel  | handshake               | word
//  ---------+-------------------------+----------------------------------
//  in       | in_valid_i / in_ready_o | in_item_t: command, byte, start
//  out      | out_valid_o/out_ready_i | out_item_t: entropy, interval, pkts
//  cfg      | cfg_valid_i/cfg_ready_o | window_slots (7 bits)
//
// Byte words: one per cycle while the queue has room, through a read-increment-write
// pipeline on the histogram memory port. A tick walks the window (one memory read a
// cycle), runs the log2 unit and serial multiplier for each nonzero symbol, does AW
// division steps, then clears the new slot. After reset a clearing pass over all
// SLOTS*256 histogram words runs with in_ready_o low. The result register lets work
// go on while out stalls.
module windowed_header_byte_entropy_core import ewhe_pkg::*; #(
  parameter int unsigned SLOTS       = SLOTS_DEF,
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_item_t   in_item_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_item_t  out_item_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [6:0] cfg_data_i
);

  logic [6:0] window_q;
  logic       q_full, q_push, q_pop, q_valid, run;
  q_item_t    push_item, head_item;

  // Window register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WINDOW_RESET;
    end else if (cfg_valid_i) begin
      window_q <= cfg_data_i;
    end
  end

  ewhe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .q_full_i    (q_full),
    .run_i       (run),
    .push_item_o (push_item),
    .push_o      (q_push)
  );

  ewhe_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (head_item)
  );

  ewhe_back #(
    .SLOTS       (SLOTS),
    .COUNT_WIDTH (COUNT_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .window_i    (window_q),
    .q_item_i    (head_item),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .run_o       (run),
    .out_item_o  (out_item_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i)
  );

endmodule

>>> sv/ewhe_front.sv
// Frame parser: tracks header position, counts packets and queues work words.
module ewhe_front import ewhe_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  in_item_t in_item_i,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     q_full_i,
  input  logic     run_i,
  output q_item_t  push_item_o,
  output logic     push_o
);

  logic [3:0]  skip_q, skip_d;
  logic [5:0]  hdr_q, hdr_d;
  logic        await_q, await_d;
  logic [31:0] pkt_q, pkt_d;
  logic        accept, count;
  logic [7:0]  masked;
  logic [3:0]  ihl;

  assign in_ready_o = run_i && !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign masked     = in_item_i.data_byte & IHL_MASK;
  assign ihl        = masked[3:0];

  // Advance the header parser on each accepted byte word
  always_comb begin
    skip_d  = skip_q;
    hdr_d   = hdr_q;
    await_d = await_q;
    pkt_d   = pkt_q;
    count   = 1'b0;
    if (accept && in_item_i.command == CMD_BYTE) begin
      if (in_item_i.packet_start) begin
        if (pkt_q != 32'hFFFF_FFFF) pkt_d = pkt_q + 32'd1;
        skip_d  = ETH_REST;
        hdr_d   = '0;
        await_d = 1'b0;
      end else if (skip_q != '0) begin
        skip_d = skip_q - 4'd1;
        if (skip_q == 4'd1) await_d = 1'b1;
      end else if (await_q) begin
        await_d = 1'b0;
        if (ihl != '0) begin
          count = 1'b1;
          hdr_d = {ihl, 2'b00} - 6'd1;
        end
      end else if (hdr_q != '0) begin
        count = 1'b1;
        hdr_d = hdr_q - 6'd1;
      end
    end
  end

  // Queue ticks and counted header bytes
  assign push_o           = accept && (in_item_i.command == CMD_TICK || count);
  assign push_item_o.kind = (in_item_i.command == CMD_TICK) ? ITEM_TICK : ITEM_COUNT;
  assign push_item_o.sym  = in_item_i.data_byte;
  assign push_item_o.pkts = pkt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q  <= '0;
      hdr_q   <= '0;
      await_q <= 1'b0;
      pkt_q   <= '0;
    end else begin
      skip_q  <= skip_d;
      hdr_q   <= hdr_d;
      await_q <= await_d;
      pkt_q   <= pkt_d;
    end
  end

endmodule

>>> sv/ewhe_fifo.sv
// Short queue of work words between the parser and the back end.
module ewhe_fifo import ewhe_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  q_item_t push_item_i,
  output logic    full_o,
  input  logic    pop_i,
  output logic    valid_o,
  output q_item_t head_o
);

  localparam int unsigned PTW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNW = $clog2(DEPTH + 1);

  q_item_t          entry_q [DEPTH];
  logic [PTW-1:0]   wr_q, rd_q;
  logic [CNW-1:0]   cnt_q;

  assign full_o  = (cnt_q == CNW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = entry_q[rd_q];

  // Hold payload words
  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_q] <= push_item_i;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PTW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      if (pop_i)  rd_q <= (rd_q == PTW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

>>> sv/ewhe_log2.sv
// Multi-cycle log2 unit: serial normalize, then 32 squaring steps (Q.32 result).
module ewhe_log2 import ewhe_pkg::*; #(
  parameter  int unsigned XW = COUNT_WIDTH_DEF + $clog2(SLOTS_DEF) + 8,
  localparam int unsigned NW = (XW > 32) ? XW : 32,
  localparam int unsigned IW = $clog2(NW),
  localparam int unsigned LW = IW + 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [XW-1:0] x_i,
  output logic          done_o,
  output logic [LW-1:0] res_o
);

  typedef enum logic [2:0] {
    LG_IDLE = 3'b001,
    LG_NORM = 3'b010,
    LG_SQR  = 3'b100
  } lg_state_e;

  lg_state_e       st_q, st_d;
  logic [NW-1:0]   y_q, y_d;
  logic [IW-1:0]   n_q, n_d;
  logic [31:0]     m_q, m_d;
  logic [31:0]     frac_q, frac_d;
  logic [4:0]      k_q, k_d;
  logic            done_q, done_d;
  logic [LW-1:0]   res_q, res_d;
  logic [63:0]     sq;
  logic [32:0]     t;

  assign sq     = m_q * m_q;
  assign t      = sq[63:31];
  assign done_o = done_q;
  assign res_o  = res_q;

  // Normalize, then square the mantissa once per fraction bit
  always_comb begin
    st_d   = st_q;
    y_d    = y_q;
    n_d    = n_q;
    m_d    = m_q;
    frac_d = frac_q;
    k_d    = k_q;
    done_d = 1'b0;
    res_d  = res_q;
    unique case (st_q)
      LG_IDLE: begin
        if (start_i) begin
          y_d  = NW'(x_i);
          n_d  = IW'(NW - 1);
          st_d = LG_NORM;
        end
      end
      LG_NORM: begin
        if (y_q[NW-1]) begin
          m_d  = y_q[NW-1 -: 32];
          k_d  = '0;
          st_d = LG_SQR;
        end else begin
          y_d = y_q << 1;
          n_d = n_q - 1'b1;
        end
      end
      LG_SQR: begin
        m_d    = t[32] ? t[32:1] : t[31:0];
        frac_d = {frac_q[30:0], t[32]};
        k_d    = k_q + 5'd1;
        if (k_q == 5'd31) begin
          done_d = 1'b1;
          res_d  = {n_q, frac_d};
          st_d   = LG_IDLE;
        end
      end
      default: st_d = LG_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= LG_IDLE;
      k_q    <= '0;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      k_q    <= k_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    y_q    <= y_d;
    n_q    <= n_d;
    m_q    <= m_d;
    frac_q <= frac_d;
    res_q  <= res_d;
  end

endmodule

>>> sv/ewhe_back.sv
// Back end: histogram memory, count pipeline, window walk, entropy and result register.
module ewhe_back import ewhe_pkg::*; #(
  parameter int unsigned SLOTS       = SLOTS_DEF,
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic [6:0] window_i,
  input  q_item_t   q_item_i,
  input  logic      q_valid_i,
  output logic      q_pop_o,
  output logic      run_o,
  output out_item_t out_item_o,
  output logic      out_valid_o,
  input  logic      out_ready_i
);

  localparam int unsigned SW  = $clog2(SLOTS);
  localparam int unsigned MAW = SW + 8;
  localparam int unsigned CW  = COUNT_WIDTH;
  localparam int unsigned PW  = COUNT_WIDTH + $clog2(SLOTS);
  localparam int unsigned TW  = PW + 8;
  localparam int unsigned NW  = (TW > 32) ? TW : 32;
  localparam int unsigned IW  = $clog2(NW);
  localparam int unsigned LW  = IW + 32;
  localparam int unsigned AW  = TW + LW;
  localparam int unsigned WCW = $clog2(SLOTS + 1);
  localparam int unsigned DCW = $clog2(AW + 1);

  typedef enum logic [11:0] {
    ST_INIT    = 12'b0000_0000_0001,
    ST_RUN     = 12'b0000_0000_0010,
    ST_P1      = 12'b0000_0000_0100,
    ST_P1_END  = 12'b0000_0000_1000,
    ST_LOGS    = 12'b0000_0001_0000,
    ST_P2_RD   = 12'b0000_0010_0000,
    ST_P2_CHK  = 12'b0000_0100_0000,
    ST_P2_LOG  = 12'b0000_1000_0000,
    ST_P2_MUL  = 12'b0001_0000_0000,
    ST_DIV     = 12'b0010_0000_0000,
    ST_EMIT    = 12'b0100_0000_0000,
    ST_CLR     = 12'b1000_0000_0000
  } st_e;

  // Histogram and per-symbol window sums
  logic [CW-1:0] mem [SLOTS*256];
  logic [PW-1:0] pmem [256];

  st_e            st_q, st_d;
  logic [15:0]    index_q, index_d;
  logic [SW-1:0]  slot_q, slot_d, ptr_q, ptr_d;
  logic [7:0]     clr_q, clr_d, sym_q, sym_d;
  logic [WCW-1:0] wcnt_q, wcnt_d, win_q, win_d;
  logic [31:0]    pkts_q, pkts_d;
  logic [TW-1:0]  total_q, total_d;
  logic [LW-1:0]  ls_q, ls_d;
  logic [AW-1:0]  acc_q, acc_d, mcand_q, mcand_d;
  logic [PW-1:0]  mplier_q, mplier_d;
  logic [TW:0]    rem_q, rem_d;
  logic [LW-1:0]  quo_q, quo_d;
  logic [DCW-1:0] dcnt_q, dcnt_d;
  logic [15:0]    ent_q, ent_d;
  logic           s2_q, s2_d;
  logic [MAW-1:0] s2_addr_q, s2_addr_d;
  logic           fw_v_q;
  logic [MAW-1:0] fw_a_q;
  logic [CW-1:0]  fw_d_q;
  logic           rv_q, rv_d, rv_first_q, rv_first_d, rv_last_q, rv_last_d;
  logic [7:0]     rv_sym_q, rv_sym_d;
  logic [PW-1:0]  psum_q, psum_d;
  logic [CW-1:0]  rdata_q;
  logic [PW-1:0]  pm_rd_q;
  out_item_t      out_q, out_d;
  logic           out_valid_q, out_valid_d;

  logic           mem_we;
  logic [MAW-1:0] mem_wa, mem_ra;
  logic [CW-1:0]  mem_wd;
  logic           pm_we;
  logic [CW-1:0]  cnt_old, cnt_new;
  logic [PW-1:0]  psum_sum;
  logic [15:0]    win_full;
  logic [TW:0]    r2;
  logic           ge;
  logic [LW-1:0]  quo_new, vsh;
  logic           log_start, log_done;
  logic [TW-1:0]  log_x;
  logic [LW-1:0]  log_res;

  ewhe_log2 #(.XW(TW)) u_log2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (log_start),
    .x_i     (log_x),
    .done_o  (log_done),
    .res_o   (log_res)
  );

  // Increment with forwarding of the write made at the previous edge
  assign cnt_old = (fw_v_q && fw_a_q == s2_addr_q) ? fw_d_q : rdata_q;
  assign cnt_new = (&cnt_old) ? cnt_old : cnt_old + 1'b1;

  // Window sum of the returning read
  assign psum_sum = (rv_first_q ? '0 : psum_q) + PW'(rdata_q);

  // Effective window, capped at the ring size
  assign win_full = (16'(window_i) > 16'(SLOTS)) ? 16'(SLOTS) : 16'(window_i);

  // One restoring division step
  assign r2      = {rem_q[TW-1:0], acc_q[AW-1]};
  assign ge      = (r2 >= {1'b0, total_q});
  assign quo_new = {quo_q[LW-2:0], ge};
  assign vsh     = quo_new >> (32 - FRAC_BITS);

  assign run_o       = (st_q != ST_INIT);
  assign out_item_o  = out_q;
  assign out_valid_o = out_valid_q;

  always_comb begin
    st_d       = st_q;
    index_d    = index_q;
    slot_d     = slot_q;
    ptr_d      = ptr_q;
    clr_d      = clr_q;
    sym_d      = sym_q;
    wcnt_d     = wcnt_q;
    win_d      = win_q;
    pkts_d     = pkts_q;
    total_d    = total_q;
    ls_d       = ls_q;
    acc_d      = acc_q;
    mcand_d    = mcand_q;
    mplier_d   = mplier_q;
    rem_d      = rem_q;
    quo_d      = quo_q;
    dcnt_d     = dcnt_q;
    ent_d      = ent_q;
    s2_d       = 1'b0;
    s2_addr_d  = s2_addr_q;
    rv_d       = 1'b0;
    rv_first_d = rv_first_q;
    rv_last_d  = rv_last_q;
    rv_sym_d   = rv_sym_q;
    psum_d     = psum_q;
    out_d      = out_q;
    q_pop_o    = 1'b0;
    log_start  = 1'b0;
    log_x      = total_q;
    pm_we      = 1'b0;
    mem_ra     = {slot_q, q_item_i.sym};
    mem_we     = s2_q;
    mem_wa     = s2_addr_q;
    mem_wd     = cnt_new;

    // Collect window sums as reads return
    if (rv_q) begin
      psum_d = psum_sum;
      if (rv_last_q) begin
        pm_we   = 1'b1;
        total_d = total_q + TW'(psum_sum);
      end
    end

    unique case (st_q)
      ST_INIT: begin
        mem_we = 1'b1;
        mem_wa = {ptr_q, clr_q};
        mem_wd = '0;
        clr_d  = clr_q + 8'd1;
        if (clr_q == 8'hFF) begin
          if (ptr_q == SW'(SLOTS - 1)) begin
            ptr_d = '0;
            st_d  = ST_RUN;
          end else begin
            ptr_d = ptr_q + 1'b1;
          end
        end
      end
      ST_RUN: begin
        if (q_valid_i) begin
          if (q_item_i.kind == ITEM_COUNT) begin
            q_pop_o   = 1'b1;
            s2_d      = 1'b1;
            s2_addr_d = {slot_q, q_item_i.sym};
          end else if (!s2_q) begin
            q_pop_o = 1'b1;
            pkts_d  = q_item_i.pkts;
            win_d   = win_full[WCW-1:0];
            if (index_q >= win_full) begin
              if (win_full == '0) begin
                ent_d = '0;
                st_d  = ST_EMIT;
              end else begin
                total_d = '0;
                sym_d   = '0;
                wcnt_d  = '0;
                ptr_d   = slot_q;
                st_d    = ST_P1;
              end
            end else begin
              index_d = index_q + 16'd1;
              slot_d  = (index_q == INTERVAL_MAX || slot_q == SW'(SLOTS - 1)) ? '0
                        : slot_q + 1'b1;
              clr_d   = '0;
              st_d    = ST_CLR;
            end
          end
        end
      end
      ST_P1: begin
        mem_ra     = {ptr_q, sym_q};
        rv_d       = 1'b1;
        rv_first_d = (wcnt_q == '0);
        rv_last_d  = (wcnt_q == win_q - 1'b1);
        rv_sym_d   = sym_q;
        if (wcnt_q == win_q - 1'b1) begin
          wcnt_d = '0;
          ptr_d  = slot_q;
          sym_d  = sym_q + 8'd1;
          if (sym_q == 8'hFF) st_d = ST_P1_END;
        end else begin
          wcnt_d = wcnt_q + 1'b1;
          ptr_d  = (ptr_q == '0) ? SW'(SLOTS - 1) : ptr_q - 1'b1;
        end
      end
      ST_P1_END: begin
        if (!rv_q) begin
          if (total_q == '0) begin
            ent_d = '0;
            st_d  = ST_EMIT;
          end else begin
            log_start = 1'b1;
            st_d      = ST_LOGS;
          end
        end
      end
      ST_LOGS: begin
        if (log_done) begin
          ls_d  = log_res;
          acc_d = '0;
          sym_d = '0;
          st_d  = ST_P2_RD;
        end
      end
      ST_P2_RD: begin
        st_d = ST_P2_CHK;
      end
      ST_P2_CHK: begin
        if (pm_rd_q == '0) begin
          if (sym_q == 8'hFF) begin
            rem_d  = '0;
            quo_d  = '0;
            dcnt_d = '0;
            st_d   = ST_DIV;
          end else begin
            sym_d = sym_q + 8'd1;
            st_d  = ST_P2_RD;
          end
        end else begin
          mplier_d  = pm_rd_q;
          log_start = 1'b1;
          log_x     = TW'(pm_rd_q);
          st_d      = ST_P2_LOG;
        end
      end
      ST_P2_LOG: begin
        if (log_done) begin
          mcand_d = AW'(ls_q - log_res);
          st_d    = ST_P2_MUL;
        end
      end
      ST_P2_MUL: begin
        if (mplier_q[0]) acc_d = acc_q + mcand_q;
        mcand_d  = mcand_q << 1;
        mplier_d = mplier_q >> 1;
        if (mplier_q[PW-1:1] == '0) begin
          if (sym_q == 8'hFF) begin
            rem_d  = '0;
            quo_d  = '0;
            dcnt_d = '0;
            st_d   = ST_DIV;
          end else begin
            sym_d = sym_q + 8'd1;
            st_d  = ST_P2_RD;
          end
        end
      end
      ST_DIV: begin
        rem_d  = ge ? r2 - {1'b0, total_q} : r2;
        quo_d  = quo_new;
        acc_d  = acc_q << 1;
        dcnt_d = dcnt_q + 1'b1;
        if (dcnt_q == DCW'(AW - 1)) begin
          ent_d = (|vsh[LW-1:16]) ? ENTROPY_MAX : vsh[15:0];
          st_d  = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.entropy_bits    = ent_q;
          out_d.closed_interval = index_q;
          out_d.packets_seen    = pkts_q;
          index_d = index_q + 16'd1;
          slot_d  = (index_q == INTERVAL_MAX || slot_q == SW'(SLOTS - 1)) ? '0
                    : slot_q + 1'b1;
          clr_d   = '0;
          st_d    = ST_CLR;
        end
      end
      ST_CLR: begin
        mem_we = 1'b1;
        mem_wa = {slot_q, clr_q};
        mem_wd = '0;
        clr_d  = clr_q + 8'd1;
        if (clr_q == 8'hFF) st_d = ST_RUN;
      end
      default: st_d = ST_INIT;
    endcase
  end

  // Load the result register on emit, drop it once taken
  assign out_valid_d = (st_q == ST_EMIT && (!out_valid_q || out_ready_i)) ? 1'b1
                       : (out_ready_i ? 1'b0 : out_valid_q);

  // Memories
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rdata_q <= mem[mem_ra];
    if (pm_we) pmem[rv_sym_q] <= psum_sum;
    pm_rd_q <= pmem[sym_q];
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_INIT;
      index_q     <= '0;
      slot_q      <= '0;
      ptr_q       <= '0;
      clr_q       <= '0;
      sym_q       <= '0;
      wcnt_q      <= '0;
      dcnt_q      <= '0;
      s2_q        <= 1'b0;
      fw_v_q      <= 1'b0;
      rv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      index_q     <= index_d;
      slot_q      <= slot_d;
      ptr_q       <= ptr_d;
      clr_q       <= clr_d;
      sym_q       <= sym_d;
      wcnt_q      <= wcnt_d;
      dcnt_q      <= dcnt_d;
      s2_q        <= s2_d;
      fw_v_q      <= s2_q;
      rv_q        <= rv_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    win_q      <= win_d;
    pkts_q     <= pkts_d;
    total_q    <= total_d;
    ls_q       <= ls_d;
    acc_q      <= acc_d;
    mcand_q    <= mcand_d;
    mplier_q   <= mplier_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    ent_q      <= ent_d;
    s2_addr_q  <= s2_addr_d;
    fw_a_q     <= s2_addr_q;
    fw_d_q     <= cnt_new;
    rv_first_q <= rv_first_d;
    rv_last_q  <= rv_last_d;
    rv_sym_q   <= rv_sym_d;
    psum_q     <= psum_d;
    out_q      <= out_d;
  end

  // The count pipeline only runs while idle in the run state
  a_s2_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_q |-> st_q == ST_RUN)
    else $error("count write outside run state");

  // Window reads return only during the first pass
  a_rv_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rv_q |-> (st_q == ST_P1 || st_q == ST_P1_END))
    else $error("window read returned outside the summing pass");

  // A tick leaves the queue only after the count pipeline has drained
  a_tick_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop_o && q_item_i.kind == ITEM_TICK) |-> !s2_q)
    else $error("tick taken with a count in flight");

  // Emitting a result fills the output register and starts the slot clear
  a_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_EMIT && (!out_valid_q || out_ready_i)) |=> (out_valid_q && st_q == ST_CLR))
    else $error("emit did not load the result");

endmodule

>>> tb/sv/windowed_header_byte_entropy_core_tb.sv
// Self-checking testbench for the windowed header byte entropy core.
module windowed_header_byte_entropy_core_tb;
  import ewhe_pkg::*;

  localparam int unsigned NSLOT     = SLOTS_DEF;
  localparam int unsigned NSYM      = 256;
  localparam int unsigned CNT_TOP   = (1 << COUNT_WIDTH_DEF) - 1;
  localparam int unsigned CYCLE_CAP = 150_000_000;
  localparam int unsigned HOLD_LEN  = 20000;

  typedef enum logic [1:0] {
    OP_ITEM   = 2'd0,
    OP_FRAME  = 2'd1,
    OP_WINDOW = 2'd2
  } row_op_e;

  typedef struct {
    row_op_e   op;
    in_item_t  item;
    logic [7:0] ihl_byte;
    int        len;
    bit        has_exp;
    out_item_t exp;
  } dir_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  in_item_t   in_item_i;
  logic       out_valid_o;
  logic       out_ready_i;
  out_item_t  out_item_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [6:0] cfg_data_i;

  // Predictor state
  int unsigned hist[NSLOT][NSYM];
  logic [15:0] cur_interval;
  logic [31:0] pkt_total;
  logic [3:0]  eth_left;
  logic [5:0]  hdr_left;
  bit          want_ihl;
  logic [6:0]  window_reg;

  out_item_t pending_results[$];
  dir_row_t  dir_tab[$];
  int        errors;
  int        items_sent;
  int        results_seen;
  longint    cycles;
  bit        hold_req;

  windowed_header_byte_entropy_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("%0t: timeout, %0d results still pending", $realtime, pending_results.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // log2 in unsigned Q.32 by repeated squaring
  function automatic logic [63:0] log2_fix(logic [63:0] x);
    int n;
    logic [63:0] y;
    logic [63:0] r;
    n = 63;
    while (n > 0 && !x[n]) n--;
    y = (n >= 31) ? (x >> (n - 31)) : (x << (31 - n));
    r = 64'(n) << 32;
    for (int k = 31; k >= 0; k--) begin
      y = (y * y) >> 31;
      if (y >= (64'd1 << 32)) begin
        y = y >> 1;
        r[k] = 1'b1;
      end
    end
    return r;
  endfunction

  // Entropy of the histogram summed over the most recent slots
  function automatic logic [15:0] window_entropy(int win);
    logic [63:0]  p[NSYM];
    logic [63:0]  total;
    logic [63:0]  ls;
    logic [127:0] acc;
    logic [127:0] q;
    int base;
    base = cur_interval % NSLOT;
    total = 0;
    acc = 0;
    for (int c = 0; c < NSYM; c++) begin
      p[c] = 0;
      for (int w = 0; w < win; w++) p[c] += hist[(base + NSLOT - w) % NSLOT][c];
      total += p[c];
    end
    if (total == 0) return 16'd0;
    ls = log2_fix(total);
    for (int c = 0; c < NSYM; c++) begin
      if (p[c] != 0) acc += {64'd0, p[c]} * {64'd0, ls - log2_fix(p[c])};
    end
    q = (acc / {64'd0, total}) >> (32 - FRAC_BITS_DEF);
    return (q > 128'hFFFF) ? ENTROPY_MAX : q[15:0];
  endfunction

  task automatic bump_count(input logic [7:0] b);
    int s;
    s = cur_interval % NSLOT;
    if (hist[s][b] < CNT_TOP) hist[s][b]++;
  endtask

  // Advance the predictor by one accepted word
  task automatic predict_item(input in_item_t it, output bit has, output out_item_t r);
    int win;
    int s;
    logic [3:0] ihl;
    has = 1'b0;
    r = '0;
    if (it.command == CMD_TICK) begin
      win = (window_reg > NSLOT) ? NSLOT : window_reg;
      if (cur_interval >= win) begin
        has = 1'b1;
        r.entropy_bits    = window_entropy(win);
        r.closed_interval = cur_interval;
        r.packets_seen    = pkt_total;
      end
      cur_interval = cur_interval + 16'd1;
      s = cur_interval % NSLOT;
      for (int c = 0; c < NSYM; c++) hist[s][c] = 0;
    end else if (it.packet_start) begin
      if (pkt_total != 32'hFFFF_FFFF) pkt_total++;
      eth_left = ETH_REST;
      hdr_left = 0;
      want_ihl = 1'b0;
    end else if (eth_left > 0) begin
      eth_left--;
      if (eth_left == 0) want_ihl = 1'b1;
    end else if (want_ihl) begin
      ihl = it.data_byte[3:0];
      want_ihl = 1'b0;
      if (ihl > 0) begin
        bump_count(it.data_byte);
        hdr_left = 6'(ihl * 4 - 1);
      end
    end else if (hdr_left > 0) begin
      bump_count(it.data_byte);
      hdr_left--;
    end
  endtask

  // Offer one word after a random gap, then log its expectation
  task automatic send_word(input in_item_t it, input bit typed, input out_item_t typed_exp);
    int gap;
    bit has;
    out_item_t r;
    gap = $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    predict_item(it, has, r);
    items_sent++;
    if (typed) pending_results.push_back(typed_exp);
    else if (has) pending_results.push_back(r);
  endtask

  task automatic send_plain(input in_item_t it);
    send_word(it, 1'b0, '0);
  endtask

  // Send a frame of len bytes; optionally drop ticks in between
  task automatic send_frame(input logic [7:0] ihl_byte, input int len, input int tick_odds);
    in_item_t it;
    for (int j = 0; j < len; j++) begin
      if (tick_odds > 0 && $urandom_range(0, tick_odds - 1) == 0) begin
        it.command = CMD_TICK;
        it.data_byte = 8'($urandom);
        it.packet_start = 1'($urandom);
        send_plain(it);
      end
      it.command = CMD_BYTE;
      it.packet_start = (j == 0);
      it.data_byte = (j == 14) ? ihl_byte : 8'($urandom);
      send_plain(it);
    end
  endtask

  // Drain, let in-flight work finish, then write the window register
  task automatic set_window(input logic [6:0] v);
    int eff;
    in_valid_i <= 1'b0;
    wait (pending_results.size() == 0);
    eff = (window_reg > NSLOT) ? NSLOT : window_reg;
    repeat (256 * eff + 256 * 160 + 1024) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    window_reg = v;
  endtask

  // Receiver: random stalls plus one long hold-off on request
  initial begin
    int stall;
    out_ready_i = 1'b0;
    wait (rst_ni);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk_i);
        hold_req = 1'b0;
      end
      stall = $urandom_range(0, 11);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Compare each accepted result word with the oldest expectation
  always @(posedge clk_i) begin
    out_item_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, out_item_o);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_item_o.entropy_bits !== e.entropy_bits) begin
          $display("%0t: entropy_bits exp %h got %h", $realtime, e.entropy_bits,
                   out_item_o.entropy_bits);
          errors++;
        end
        if (out_item_o.closed_interval !== e.closed_interval) begin
          $display("%0t: closed_interval exp %h got %h", $realtime, e.closed_interval,
                   out_item_o.closed_interval);
          errors++;
        end
        if (out_item_o.packets_seen !== e.packets_seen) begin
          $display("%0t: packets_seen exp %h got %h", $realtime, e.packets_seen,
                   out_item_o.packets_seen);
          errors++;
        end
      end
    end
  end

  function automatic dir_row_t mk_row(row_op_e op, logic cmd, logic [7:0] d, logic st,
                                      logic [7:0] ihl_b, int len, bit has,
                                      logic [15:0] ent, logic [15:0] ci, logic [31:0] pk);
    dir_row_t r;
    r.op = op;
    r.item.command = cmd;
    r.item.data_byte = d;
    r.item.packet_start = st;
    r.ihl_byte = ihl_b;
    r.len = len;
    r.has_exp = has;
    r.exp.entropy_bits = ent;
    r.exp.closed_interval = ci;
    r.exp.packets_seen = pk;
    return r;
  endfunction

  // Main stimulus
  initial begin
    in_item_t it;
    logic [6:0] phase_win[4];
    int phase_len[4];
    int target;
    int len;
    logic [3:0] ihl;
    errors = 0;
    items_sent = 0;
    results_seen = 0;
    cycles = 0;
    hold_req = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    for (int s = 0; s < NSLOT; s++)
      for (int c = 0; c < NSYM; c++) hist[s][c] = 0;
    cur_interval = 0;
    pkt_total = 0;
    eth_left = 0;
    hdr_left = 0;
    want_ihl = 1'b0;
    window_reg = WINDOW_RESET;

    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows: window zero, early ticks, empty windows, frame corner cases
    dir_tab.push_back(mk_row(OP_WINDOW, 0, 8'd0, 0, 8'd0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(OP_ITEM, CMD_TICK, 8'h00, 0, 8'd0, 0, 1, 16'd0, 16'd0, 32'd0));
    dir_tab.push_back(mk_row(OP_ITEM, CMD_TICK, 8'hFF, 1, 8'd0, 0, 1, 16'd0, 16'd1, 32'd0));
    dir_tab.push_back(mk_row(OP_WINDOW, 0, 8'd3, 0, 8'd0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(OP_ITEM, CMD_TICK, 8'h00, 0, 8'd0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(OP_ITEM, CMD_TICK, 8'h00, 0, 8'd0, 0, 1, 16'd0, 16'd3, 32'd0));
    dir_tab.push_back(mk_row(OP_ITEM, CMD_BYTE, 8'h5A, 0, 8'd0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(OP_FRAME, 0, 8'd0, 0, 8'h45, 34, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(OP_ITEM, CMD_BYTE, 8'hAA, 0, 8'd0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(OP_FRAME, 0, 8'd0, 0, 8'h40, 20, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(OP_FRAME, 0, 8'd0, 0, 8'hFF, 74, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(OP_FRAME, 0, 8'd0, 0, 8'h46, 18, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(OP_FRAME, 0, 8'd0, 0, 8'h0F, 74, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(OP_ITEM, CMD_TICK, 8'h00, 0, 8'd0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(OP_WINDOW, 0, 8'd1, 0, 8'd0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(OP_ITEM, CMD_TICK, 8'h00, 0, 8'd0, 0, 1, 16'd0, 16'd5, 32'd5));
    dir_tab.push_back(mk_row(OP_WINDOW, 0, 8'd127, 0, 8'd0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(OP_ITEM, CMD_TICK, 8'h00, 0, 8'd0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(OP_ITEM, CMD_TICK, 8'hFF, 1, 8'd0, 0, 0, 0, 0, 0));

    foreach (dir_tab[i]) begin
      case (dir_tab[i].op)
        OP_ITEM: begin
          send_word(dir_tab[i].item, dir_tab[i].has_exp, dir_tab[i].exp);
        end
        OP_FRAME: begin
          send_frame(dir_tab[i].ihl_byte, dir_tab[i].len, 0);
        end
        default: begin
          set_window(dir_tab[i].item.data_byte[6:0]);
        end
      endcase
    end

    // Random phases; the last uses the full window for only a few ticks
    phase_win[0] = 7'd2;  phase_len[0] = 130;
    phase_win[1] = 7'd1;  phase_len[1] = 130;
    phase_win[2] = 7'd7;  phase_len[2] = 130;
    phase_win[3] = 7'd64; phase_len[3] = 150;
    for (int ph = 0; ph < 4; ph++) begin
      set_window(phase_win[ph]);
      target = items_sent + phase_len[ph];
      if (ph == 1) begin
        // Hold the receiver off while ticks pile up behind it
        hold_req = 1'b1;
        repeat (12) begin
          it.command = CMD_TICK;
          it.data_byte = 8'($urandom);
          it.packet_start = 1'($urandom);
          send_plain(it);
        end
      end
      while (items_sent < target) begin
        if ($urandom_range(0, 4) == 0) begin
          it = in_item_t'($urandom);
          send_plain(it);
        end else begin
          ihl = 4'($urandom);
          case ($urandom_range(0, 2))
            0: len = $urandom_range(1, 20);
            1: len = 15 + ihl * 4 + $urandom_range(0, 3);
            default: len = $urandom_range(1, 78);
          endcase
          send_frame({4'($urandom), ihl}, len, (ph == 3) ? 60 : 14);
        end
        if (ph == 2 && items_sent >= target - 100 && items_sent < target - 90) begin
          // Pause the sender until every result is back
          in_valid_i <= 1'b0;
          wait (pending_results.size() == 0);
        end
      end
    end

    in_valid_i <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (256 * NSLOT + 256 * 160 + 1024) @(posedge clk_i);
    $display("Sent %0d words over windows 0, 1, 2, 3, 7, 64 and 127; checked %0d results.",
             items_sent, results_seen);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
